// ===== hw/rtl/spmc_pkg.sv =====
// shared types, widths and codes for the sigma point mean / covariance core
// no dependencies; used by spmc_mac and sigma_point_mean_covariance_core
package spmc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int MAX_DIM    = 6;

    localparam int PT_IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PT_AW  = (MAX_POINTS * MAX_DIM > 1) ? $clog2(MAX_POINTS * MAX_DIM) : 1;
    localparam int DIM_IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam int VAL_W  = 32;
    localparam int WGT_W  = 24;
    localparam int PC_W   = 5;
    localparam int DIM_W  = 3;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_W    = 49;
    localparam int ACC_W  = 78;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION   = 1'b1;

    localparam int KIND_BIT = 0;
    localparam int ERR_BIT  = 1;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
        logic acc_shift;
    } mac_ctrl_t;

    typedef enum logic [16:0] {
        S_IDLE   = 17'd1 << 0,
        S_ERR    = 17'd1 << 1,
        S_M_RD   = 17'd1 << 2,
        S_M_MUL  = 17'd1 << 3,
        S_M_ACC  = 17'd1 << 4,
        S_M_OUT  = 17'd1 << 5,
        S_C_MR   = 17'd1 << 6,
        S_C_MC   = 17'd1 << 7,
        S_C_RDR  = 17'd1 << 8,
        S_C_RDC  = 17'd1 << 9,
        S_C_DEV  = 17'd1 << 10,
        S_C_MAG  = 17'd1 << 11,
        S_C_RND  = 17'd1 << 12,
        S_C_MULH = 17'd1 << 13,
        S_C_MULL = 17'd1 << 14,
        S_C_ACCL = 17'd1 << 15,
        S_C_OUT  = 17'd1 << 16
    } state_t;

endpackage

// ===== hw/rtl/sigma_point_mean_covariance_core.sv =====
// loads are taken one per cycle while idle; a bad window gives its one result from the
// error state once the output register is free; compute: every mean row and covariance
// entry runs over the np points in use, all through the one shared multiply-accumulate
// unit; not ready until the last result is in the output register
// reset: synchronous active low, clears sequencer, config (1, 1) and output valid;
// store contents are not cleared
module sigma_point_mean_covariance_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [spmc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [spmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input item channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_index, element_index, element_value, mean_weight, cov_weight,
    // sub_dimension, margin_begin, zero pad
    input  logic [spmc_pkg::IN_DATA_W-1:0]      s_tdata,
    // command
    input  logic                                s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_value, row, column, zero pad
    output logic [spmc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // result_kind, window_error
    output logic [spmc_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);

    localparam int VAL_W  = spmc_pkg::VAL_W;
    localparam int WGT_W  = spmc_pkg::WGT_W;
    localparam int PT_IW  = spmc_pkg::PT_IW;
    localparam int PT_AW  = spmc_pkg::PT_AW;
    localparam int DIM_IW = spmc_pkg::DIM_IW;
    localparam int PC_W   = spmc_pkg::PC_W;
    localparam int DIM_W  = spmc_pkg::DIM_W;
    localparam int MUL_W  = spmc_pkg::MUL_W;
    localparam int PROD_W = spmc_pkg::PROD_W;
    localparam int Q_W    = spmc_pkg::Q_W;
    localparam int ACC_W  = spmc_pkg::ACC_W;
    localparam int RND_W  = ACC_W - 16;

    // input field views
    logic [3:0]       in_point;
    logic [2:0]       in_elem;
    logic [VAL_W-1:0] in_value;
    logic [WGT_W-1:0] in_mw;
    logic [WGT_W-1:0] in_cw;
    logic [2:0]       in_sub;
    logic [2:0]       in_beg;

    assign in_point = s_tdata[3:0];
    assign in_elem  = s_tdata[6:4];
    assign in_value = s_tdata[38:7];
    assign in_mw    = s_tdata[62:39];
    assign in_cw    = s_tdata[86:63];
    assign in_sub   = s_tdata[89:87];
    assign in_beg   = s_tdata[92:90];

    spmc_pkg::state_t state_reg, state_next;

    logic [PC_W-1:0]  pc_reg;
    logic [DIM_W-1:0] dim_reg;
    logic [2:0]       r_reg, r_next;
    logic [2:0]       c_reg, c_next;
    logic [PT_IW-1:0] i_reg, i_next;
    logic [2:0]       sub_reg, sub_next;
    logic [2:0]       beg_reg, beg_next;
    logic [PC_W-1:0]  np_reg, np_next;
    logic [VAL_W-1:0] mr_reg, mr_next;
    logic [VAL_W-1:0] mc_reg, mc_next;
    logic [VAL_W:0]   dr_reg, dr_next;
    logic [VAL_W:0]   dc_reg, dc_next;
    logic             neg_reg, neg_next;
    logic [Q_W-1:0]   q_reg, q_next;

    logic                  m_valid_reg;
    logic [VAL_W-1:0]      m_value_reg;
    logic                  m_kind_reg;
    logic [2:0]            m_row_reg;
    logic [2:0]            m_col_reg;
    logic                  m_err_reg;
    logic                  m_last_reg;

    logic [VAL_W-1:0] mean_vec [spmc_pkg::MAX_DIM];

    // effective settings
    logic [PC_W-1:0]  np_eff;
    logic [DIM_W-1:0] dim_eff;
    logic [2:0]       sub_eff;
    logic             win_err;

    assign np_eff  = (pc_reg > PC_W'(spmc_pkg::MAX_POINTS)) ? PC_W'(spmc_pkg::MAX_POINTS)
                                                            : pc_reg;
    assign dim_eff = (dim_reg > DIM_W'(spmc_pkg::MAX_DIM)) ? DIM_W'(spmc_pkg::MAX_DIM)
                                                           : dim_reg;
    assign sub_eff = (in_sub == 3'd0) ? dim_eff : in_sub;
    assign win_err = (sub_eff == 3'd0) ||
                     (({1'b0, in_beg} + {1'b0, sub_eff}) > {1'b0, dim_eff});

    // memories
    logic                   pt_we;
    logic [PT_AW-1:0]       pt_waddr;
    logic [PT_AW-1:0]       pt_raddr;
    logic [VAL_W-1:0]       pt_rdata;
    logic                   w_we;
    logic [2*WGT_W-1:0]     w_rdata;
    logic [WGT_W-1:0]       wm;
    logic [WGT_W-1:0]       wc;

    function automatic logic [PT_AW-1:0] pt_addr(input logic [PT_IW-1:0] p,
                                                 input logic [3:0] e);
        pt_addr = PT_AW'(p) * PT_AW'(spmc_pkg::MAX_DIM) + PT_AW'(e);
    endfunction

    assign pt_we    = s_tvalid && s_tready && (s_tuser == spmc_pkg::CMD_LOAD) &&
                      (int'(in_point) < spmc_pkg::MAX_POINTS) &&
                      (int'(in_elem) < spmc_pkg::MAX_DIM);
    assign w_we     = pt_we;
    assign pt_waddr = pt_addr(PT_IW'(in_point), {1'b0, in_elem});

    spmc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (spmc_pkg::MAX_POINTS * spmc_pkg::MAX_DIM)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (in_value),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    spmc_ram #(
        .WIDTH (2 * WGT_W),
        .DEPTH (spmc_pkg::MAX_POINTS)
    ) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (PT_IW'(in_point)),
        .wdata ({in_cw, in_mw}),
        .raddr (i_reg),
        .rdata (w_rdata)
    );

    assign wm = w_rdata[WGT_W-1:0];
    assign wc = w_rdata[2*WGT_W-1:WGT_W];

    // shared multiply-accumulate unit
    spmc_pkg::mac_ctrl_t       mac_ctrl;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;

    spmc_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .acc   (acc)
    );

    // round the accumulator to Q16.16 and saturate
    logic [ACC_W-1:0] acc_rnd;
    logic [RND_W-1:0] acc_sh;
    logic [VAL_W-1:0] acc_sat;

    always_comb begin
        acc_rnd = acc + ACC_W'(32768);
        acc_sh  = acc_rnd[ACC_W-1:16];
        if (!acc_sh[RND_W-1] && (|acc_sh[RND_W-2:VAL_W-1])) begin
            acc_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (acc_sh[RND_W-1] && !(&acc_sh[RND_W-2:VAL_W-1])) begin
            acc_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            acc_sat = acc_sh[VAL_W-1:0];
        end
    end

    // product rounding helpers
    logic [63:0]    mag_sum;
    logic [VAL_W:0] dr_abs;
    logic [VAL_W:0] dc_abs;

    assign mag_sum = prod[63:0] + 64'd32768;
    assign dr_abs  = dr_reg[VAL_W] ? (~dr_reg + 1'b1) : dr_reg;
    assign dc_abs  = dc_reg[VAL_W] ? (~dc_reg + 1'b1) : dc_reg;

    logic             out_free;
    logic             out_load;
    logic [VAL_W-1:0] out_value;
    logic             out_kind;
    logic             out_err;
    logic             out_last;
    logic             mv_we;
    logic [VAL_W-1:0] mv_rdata;
    logic [2:0]       mv_idx;
    logic             last_pt;

    assign out_free = !m_valid_reg || m_tready;
    assign last_pt  = ((PC_W'(i_reg) + PC_W'(1)) == np_reg);
    assign mv_idx   = (state_reg == spmc_pkg::S_C_MR) ? r_reg : c_reg;
    assign mv_rdata = mean_vec[mv_idx[DIM_IW-1:0]];

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        sub_next   = sub_reg;
        beg_next   = beg_reg;
        np_next    = np_reg;
        mr_next    = mr_reg;
        mc_next    = mc_reg;
        dr_next    = dr_reg;
        dc_next    = dc_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;
        mac_ctrl   = '0;
        mul_a      = '0;
        mul_b      = '0;
        pt_raddr   = pt_addr(i_reg, {1'b0, beg_reg} + {1'b0, r_reg});
        mv_we      = 1'b0;
        out_load   = 1'b0;
        out_value  = '0;
        out_kind   = 1'b0;
        out_err    = 1'b0;
        out_last   = 1'b0;

        case (state_reg)
            spmc_pkg::S_IDLE: begin
                if (s_tvalid && (s_tuser == spmc_pkg::CMD_COMPUTE)) begin
                    sub_next = sub_eff;
                    beg_next = in_beg;
                    np_next  = np_eff;
                    r_next   = '0;
                    c_next   = '0;
                    i_next   = '0;
                    mac_ctrl.acc_clr = 1'b1;
                    if (win_err) begin
                        state_next = spmc_pkg::S_ERR;
                    end else if (np_eff == '0) begin
                        state_next = spmc_pkg::S_M_OUT;
                    end else begin
                        state_next = spmc_pkg::S_M_RD;
                    end
                end
            end
            spmc_pkg::S_ERR: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_err    = 1'b1;
                    out_last   = 1'b1;
                    state_next = spmc_pkg::S_IDLE;
                end
            end
            spmc_pkg::S_M_RD: begin
                state_next = spmc_pkg::S_M_MUL;
            end
            spmc_pkg::S_M_MUL: begin
                mac_ctrl.mul_en = 1'b1;
                mul_a = {{(MUL_W-WGT_W){wm[WGT_W-1]}}, wm};
                mul_b = {{(MUL_W-VAL_W){pt_rdata[VAL_W-1]}}, pt_rdata};
                state_next = spmc_pkg::S_M_ACC;
            end
            spmc_pkg::S_M_ACC: begin
                mac_ctrl.acc_add = 1'b1;
                if (last_pt) begin
                    state_next = spmc_pkg::S_M_OUT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = spmc_pkg::S_M_RD;
                end
            end
            spmc_pkg::S_M_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_value = acc_sat;
                    mv_we     = 1'b1;
                    mac_ctrl.acc_clr = 1'b1;
                    i_next    = '0;
                    if (r_reg == sub_reg - 3'd1) begin
                        r_next     = '0;
                        state_next = spmc_pkg::S_C_MR;
                    end else begin
                        r_next     = r_reg + 3'd1;
                        state_next = (np_reg == '0) ? spmc_pkg::S_M_OUT : spmc_pkg::S_M_RD;
                    end
                end
            end
            spmc_pkg::S_C_MR: begin
                mr_next    = mv_rdata;
                state_next = spmc_pkg::S_C_MC;
            end
            spmc_pkg::S_C_MC: begin
                mc_next    = mv_rdata;
                state_next = (np_reg == '0) ? spmc_pkg::S_C_OUT : spmc_pkg::S_C_RDR;
            end
            spmc_pkg::S_C_RDR: begin
                state_next = spmc_pkg::S_C_RDC;
            end
            spmc_pkg::S_C_RDC: begin
                pt_raddr   = pt_addr(i_reg, {1'b0, beg_reg} + {1'b0, c_reg});
                dr_next    = {pt_rdata[VAL_W-1], pt_rdata} - {mr_reg[VAL_W-1], mr_reg};
                state_next = spmc_pkg::S_C_DEV;
            end
            spmc_pkg::S_C_DEV: begin
                dc_next    = {pt_rdata[VAL_W-1], pt_rdata} - {mc_reg[VAL_W-1], mc_reg};
                state_next = spmc_pkg::S_C_MAG;
            end
            spmc_pkg::S_C_MAG: begin
                // magnitudes fit 32 bits, so both operands stay non-negative
                mac_ctrl.mul_en = 1'b1;
                mul_a    = {1'b0, dr_abs[VAL_W-1:0]};
                mul_b    = {1'b0, dc_abs[VAL_W-1:0]};
                neg_next = dr_reg[VAL_W] ^ dc_reg[VAL_W];
                state_next = spmc_pkg::S_C_RND;
            end
            spmc_pkg::S_C_RND: begin
                // half away from zero on the magnitude, then apply the sign
                if (neg_reg) begin
                    q_next = Q_W'(0) - {1'b0, mag_sum[63:16]};
                end else begin
                    q_next = {1'b0, mag_sum[63:16]};
                end
                state_next = spmc_pkg::S_C_MULH;
            end
            spmc_pkg::S_C_MULH: begin
                mac_ctrl.mul_en = 1'b1;
                mul_a = q_reg[Q_W-1:16];
                mul_b = {{(MUL_W-WGT_W){wc[WGT_W-1]}}, wc};
                state_next = spmc_pkg::S_C_MULL;
            end
            spmc_pkg::S_C_MULL: begin
                mac_ctrl.acc_add   = 1'b1;
                mac_ctrl.acc_shift = 1'b1;
                mac_ctrl.mul_en    = 1'b1;
                mul_a = {{(MUL_W-16){1'b0}}, q_reg[15:0]};
                mul_b = {{(MUL_W-WGT_W){wc[WGT_W-1]}}, wc};
                state_next = spmc_pkg::S_C_ACCL;
            end
            spmc_pkg::S_C_ACCL: begin
                mac_ctrl.acc_add = 1'b1;
                if (last_pt) begin
                    state_next = spmc_pkg::S_C_OUT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = spmc_pkg::S_C_RDR;
                end
            end
            spmc_pkg::S_C_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_value = acc_sat;
                    out_kind  = 1'b1;
                    mac_ctrl.acc_clr = 1'b1;
                    i_next    = '0;
                    state_next = spmc_pkg::S_C_MR;
                    if (c_reg == sub_reg - 3'd1) begin
                        c_next = '0;
                        if (r_reg == sub_reg - 3'd1) begin
                            out_last   = 1'b1;
                            r_next     = '0;
                            state_next = spmc_pkg::S_IDLE;
                        end else begin
                            r_next = r_reg + 3'd1;
                        end
                    end else begin
                        c_next = c_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = spmc_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spmc_pkg::S_IDLE;
            pc_reg      <= PC_W'(1);
            dim_reg     <= DIM_W'(1);
            r_reg       <= '0;
            c_reg       <= '0;
            i_reg       <= '0;
            sub_reg     <= '0;
            beg_reg     <= '0;
            np_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            sub_reg   <= sub_next;
            beg_reg   <= beg_next;
            np_reg    <= np_next;
            if (cfg_we) begin
                case (cfg_addr)
                    spmc_pkg::REG_POINT_COUNT: pc_reg  <= cfg_wdata[PC_W-1:0];
                    spmc_pkg::REG_DIMENSION:   dim_reg <= cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mr_reg  <= mr_next;
        mc_reg  <= mc_next;
        dr_reg  <= dr_next;
        dc_reg  <= dc_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        if (mv_we) begin
            mean_vec[r_reg[DIM_IW-1:0]] <= acc_sat;
        end
        if (out_load) begin
            m_value_reg <= out_value;
            m_kind_reg  <= out_kind;
            m_row_reg   <= out_err ? 3'd0 : r_reg;
            m_col_reg   <= out_kind ? c_reg : 3'd0;
            m_err_reg   <= out_err;
            m_last_reg  <= out_last;
        end
    end

    assign s_tready = (state_reg == spmc_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(spmc_pkg::OUT_DATA_W - VAL_W - 6){1'b0}},
                       m_col_reg, m_row_reg, m_value_reg};
    assign m_tuser  = {m_err_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

    // the final result of a run is a covariance entry or the window error
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[spmc_pkg::KIND_BIT] || m_tuser[spmc_pkg::ERR_BIT]))
        else $error("last item is neither covariance nor error");

    // an error item is the whole run and carries nothing else
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[spmc_pkg::ERR_BIT]) |->
        (m_tlast && !m_tuser[spmc_pkg::KIND_BIT] && (m_tdata == '0)))
        else $error("error item malformed");

    // while computing, the walk stays inside the accepted window
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != spmc_pkg::S_IDLE) && (state_reg != spmc_pkg::S_ERR)) |->
        ((r_reg < sub_reg) && (c_reg < sub_reg) &&
         (({1'b0, beg_reg} + {1'b0, sub_reg}) <= {1'b0, dim_eff})))
        else $error("row or column outside window");

    // a new item appears only from a result-producing state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past((state_reg == spmc_pkg::S_ERR) ||
                                  (state_reg == spmc_pkg::S_M_OUT) ||
                                  (state_reg == spmc_pkg::S_C_OUT)))
        else $error("result item without a producing state");

endmodule

// ===== hw/rtl/spmc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module spmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/spmc_mac.sv =====
// shared multiply-accumulate unit: 33x33 signed multiplier with registered
// product and a wide accumulator; depends on spmc_pkg
module spmc_mac (
    input  logic                               aclk,
    input  spmc_pkg::mac_ctrl_t                ctrl,
    input  logic signed [spmc_pkg::MUL_W-1:0]  mul_a,
    input  logic signed [spmc_pkg::MUL_W-1:0]  mul_b,
    output logic signed [spmc_pkg::PROD_W-1:0] prod,
    output logic signed [spmc_pkg::ACC_W-1:0]  acc
);

    logic signed [spmc_pkg::PROD_W-1:0] prod_reg;
    logic signed [spmc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [spmc_pkg::ACC_W-1:0]  acc_next;
    logic signed [spmc_pkg::ACC_W-1:0]  addend;

    always_comb begin
        addend = {{(spmc_pkg::ACC_W - spmc_pkg::PROD_W){prod_reg[spmc_pkg::PROD_W-1]}},
                  prod_reg};
        // high partial product carries weight 2^16
        if (ctrl.acc_shift) begin
            addend = addend <<< 16;
        end
        acc_next = acc_reg;
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (ctrl.acc_add) begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule
